### rtl/core/blqr_pkg.sv
// Package for the balancing LQR wheel current unit.
// Holds widths, register indexes, command codes and the controller state type.
// No dependencies.
package blqr_pkg;

  // fixed-point format of gains and angle inputs
  localparam int FRAC_BITS  = 12;

  // field widths
  localparam int RPM_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int KPT_W      = 23;
  localparam int CUR_W      = 16;

  // datapath widths
  localparam int D_W        = RPM_W + 2;              // twice the speed error
  localparam int TQ_W       = FRAC_BITS + 18;         // clamped torque, +-2^(F+16)
  localparam int OPA_W      = TQ_W;                   // multiplier operand A
  localparam int PROD_W     = OPA_W + GAIN_W;         // multiplier product
  localparam int GP_W       = GAIN_W + D_W;           // gain product range
  localparam int ACC_W      = GP_W + FRAC_BITS + 2;   // feedback accumulator

  // stream payload widths
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  // input flag positions in tuser
  localparam int UB_ZERO_FORCE = 0;
  localparam int UB_REMOTE_LOST = 1;
  localparam int UB_MOTORS_OFF = 2;

  // configuration register map
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_SPEED     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_PITCH     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_PITCH_RT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_HEAD_L    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_YAW_RT_L  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_HEAD_R    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_YAW_RT_R  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CUR_PER_TQ     = 3'd7;

  // multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SPD,
    MUL_PA,
    MUL_PR,
    MUL_HR,
    MUL_YR,
    MUL_HL,
    MUL_YL,
    MUL_CR,
    MUL_CL
  } mul_sel_t;

  // accumulator / conversion operations
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_LOAD_SHF,
    ACC_SUB2,
    ACC_SUB2_COPY,
    ACC_ADD2,
    ACC_TR_COM2,
    ACC_NEG_CURR,
    ACC_TL,
    ACC_CURL
  } acc_op_t;

  // controller to datapath command group
  typedef struct packed {
    logic     in_load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     out_load;
  } dp_cmd_t;

  // controller states, one per sequencing step
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD,
    ST_PA,
    ST_PR,
    ST_HR,
    ST_YR,
    ST_HL,
    ST_YL,
    ST_CR,
    ST_NEGR,
    ST_TL,
    ST_CL,
    ST_CURL,
    ST_OUT
  } blqr_state_t;

endpackage

### rtl/core/blqr_ctrl.sv
// Sequencer for the balancing LQR wheel current unit.
// Steps the shared multiplier and accumulator, owns the handshakes; uses blqr_pkg.
module blqr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_zero_force,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output blqr_pkg::dp_cmd_t cmd
);
  import blqr_pkg::*;

  blqr_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.in_load  = 1'b0;
    cmd.mul_sel  = MUL_NONE;
    cmd.acc_op   = ACC_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = in_zero_force ? ST_OUT : ST_SPD;
        end
      end
      ST_SPD: begin
        cmd.mul_sel = MUL_SPD;
        state_nxt   = ST_PA;
      end
      ST_PA: begin
        cmd.mul_sel = MUL_PA;
        cmd.acc_op  = ACC_LOAD_SHF;
        state_nxt   = ST_PR;
      end
      ST_PR: begin
        cmd.mul_sel = MUL_PR;
        cmd.acc_op  = ACC_SUB2;
        state_nxt   = ST_HR;
      end
      ST_HR: begin
        cmd.mul_sel = MUL_HR;
        cmd.acc_op  = ACC_SUB2_COPY;
        state_nxt   = ST_YR;
      end
      ST_YR: begin
        cmd.mul_sel = MUL_YR;
        cmd.acc_op  = ACC_ADD2;
        state_nxt   = ST_HL;
      end
      ST_HL: begin
        cmd.mul_sel = MUL_HL;
        cmd.acc_op  = ACC_ADD2;
        state_nxt   = ST_YL;
      end
      ST_YL: begin
        cmd.mul_sel = MUL_YL;
        cmd.acc_op  = ACC_TR_COM2;
        state_nxt   = ST_CR;
      end
      ST_CR: begin
        cmd.mul_sel = MUL_CR;
        cmd.acc_op  = ACC_ADD2;
        state_nxt   = ST_NEGR;
      end
      ST_NEGR: begin
        cmd.acc_op  = ACC_NEG_CURR;
        state_nxt   = ST_TL;
      end
      ST_TL: begin
        cmd.acc_op  = ACC_TL;
        state_nxt   = ST_CL;
      end
      ST_CL: begin
        cmd.mul_sel = MUL_CL;
        state_nxt   = ST_CURL;
      end
      ST_CURL: begin
        cmd.acc_op  = ACC_CURL;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output beat held until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### rtl/core/blqr_dpath.sv
// Datapath of the balancing LQR wheel current unit: gain registers, operand
// latches, shared multiplier, accumulator, current conversion. Uses blqr_pkg.
module blqr_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  blqr_pkg::dp_cmd_t                  cmd,
  input  logic                               cfg_we,
  input  logic [blqr_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [blqr_pkg::GAIN_W-1:0]        cfg_wdata,
  input  logic [blqr_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [blqr_pkg::IN_USER_W-1:0]     in_tuser,
  output logic [blqr_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [blqr_pkg::OUT_USER_W-1:0]    out_tuser
);
  import blqr_pkg::*;

  localparam logic signed [ACC_W-1:0]  TQ_BIAS = ACC_W'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [ACC_W-1:0]  TQ_LIM  = ACC_W'(1) <<< (FRAC_BITS + 16);
  localparam logic signed [PROD_W-1:0] CU_BIAS = PROD_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [PROD_W-1:0] CU_MAX  = PROD_W'((1 << (CUR_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] CU_MIN  = -CU_MAX - PROD_W'(1);

  // configuration registers
  logic signed [GAIN_W-1:0] g_spd_r, g_pa_r, g_pr_r, g_hl_r, g_yl_r, g_hr_r, g_yr_r;
  logic        [KPT_W-1:0]  kpt_r;

  // latched operands
  logic signed [RPM_W-1:0]  rl_r, rr_r, sp_r, pa_r, pr_r, yr_r, he_r;
  logic                     rlost_r, moff_r;

  // arithmetic state
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, com_r;
  logic signed [TQ_W-1:0]   tr_r, tl_r;
  logic signed [CUR_W-1:0]  held_l_r, held_r_r;

  // output register
  logic        [OUT_DATA_W-1:0] out_data_r;
  logic                         out_send_r;

  logic signed [D_W-1:0]    d;
  logic signed [OPA_W-1:0]  opa;
  logic signed [GAIN_W-1:0] opb;
  logic signed [GP_W-1:0]   gp;
  logic signed [ACC_W-1:0]  gp_ext, gp2;

  // torque: divide by 2^(F+1) toward zero, then clamp
  function automatic logic signed [TQ_W-1:0] tq_of(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] q;
    begin
      b = '0;
      if (a[ACC_W-1]) b = TQ_BIAS;
      q = (a + b) >>> (FRAC_BITS + 1);
      if (q > TQ_LIM)       q = TQ_LIM;
      else if (q < -TQ_LIM) q = -TQ_LIM;
      return q[TQ_W-1:0];
    end
  endfunction

  // current: divide by 2^F toward zero, then saturate
  function automatic logic signed [CUR_W-1:0] cur_of(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    logic signed [PROD_W-1:0] q;
    begin
      b = '0;
      if (p[PROD_W-1]) b = CU_BIAS;
      q = (p + b) >>> FRAC_BITS;
      if (q > CU_MAX)      q = CU_MAX;
      else if (q < CU_MIN) q = CU_MIN;
      return q[CUR_W-1:0];
    end
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_spd_r <= '0;
      g_pa_r  <= '0;
      g_pr_r  <= '0;
      g_hl_r  <= '0;
      g_yl_r  <= '0;
      g_hr_r  <= '0;
      g_yr_r  <= '0;
      kpt_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_SPEED:    g_spd_r <= cfg_wdata;
        REG_GAIN_PITCH:    g_pa_r  <= cfg_wdata;
        REG_GAIN_PITCH_RT: g_pr_r  <= cfg_wdata;
        REG_GAIN_HEAD_L:   g_hl_r  <= cfg_wdata;
        REG_GAIN_YAW_RT_L: g_yl_r  <= cfg_wdata;
        REG_GAIN_HEAD_R:   g_hr_r  <= cfg_wdata;
        REG_GAIN_YAW_RT_R: g_yr_r  <= cfg_wdata;
        REG_CUR_PER_TQ:    kpt_r   <= cfg_wdata[KPT_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat latch
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      rl_r    <= in_tdata[15:0];
      rr_r    <= in_tdata[31:16];
      sp_r    <= in_tdata[47:32];
      pa_r    <= in_tdata[63:48];
      pr_r    <= in_tdata[79:64];
      yr_r    <= in_tdata[95:80];
      he_r    <= in_tdata[111:96];
      rlost_r <= in_tuser[UB_REMOTE_LOST];
      moff_r  <= in_tuser[UB_MOTORS_OFF];
    end
  end

  // twice the speed error
  assign d = {{2{rl_r[RPM_W-1]}}, rl_r} - {{2{rr_r[RPM_W-1]}}, rr_r}
           - {sp_r[RPM_W-1], sp_r, 1'b0};

  // multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      MUL_SPD: begin opa = {{(OPA_W-D_W){d[D_W-1]}}, d};             opb = g_spd_r; end
      MUL_PA:  begin opa = {{(OPA_W-RPM_W){pa_r[RPM_W-1]}}, pa_r};   opb = g_pa_r;  end
      MUL_PR:  begin opa = {{(OPA_W-RPM_W){pr_r[RPM_W-1]}}, pr_r};   opb = g_pr_r;  end
      MUL_HR:  begin opa = {{(OPA_W-RPM_W){he_r[RPM_W-1]}}, he_r};   opb = g_hr_r;  end
      MUL_YR:  begin opa = {{(OPA_W-RPM_W){yr_r[RPM_W-1]}}, yr_r};   opb = g_yr_r;  end
      MUL_HL:  begin opa = {{(OPA_W-RPM_W){he_r[RPM_W-1]}}, he_r};   opb = g_hl_r;  end
      MUL_YL:  begin opa = {{(OPA_W-RPM_W){yr_r[RPM_W-1]}}, yr_r};   opb = g_yl_r;  end
      MUL_CR:  begin opa = tr_r;                                     opb = {1'b0, kpt_r}; end
      MUL_CL:  begin opa = tl_r;                                     opb = {1'b0, kpt_r}; end
      default: begin opa = '0;                                       opb = '0;      end
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE)
      prod_r <= opa * opb;
  end

  // gain product, sign-extended and doubled
  assign gp     = prod_r[GP_W-1:0];
  assign gp_ext = {{(ACC_W-GP_W){gp[GP_W-1]}}, gp};
  assign gp2    = gp_ext <<< 1;

  // feedback accumulation and torque capture
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_LOAD_SHF:  acc_r <= gp_ext <<< FRAC_BITS;
      ACC_SUB2:      acc_r <= acc_r - gp2;
      ACC_SUB2_COPY: begin
        acc_r <= acc_r - gp2;
        com_r <= acc_r - gp2;
      end
      ACC_ADD2:      acc_r <= acc_r + gp2;
      ACC_TR_COM2: begin
        tr_r  <= tq_of(acc_r);
        acc_r <= com_r + gp2;
      end
      ACC_NEG_CURR:  acc_r <= -acc_r;
      ACC_TL:        tl_r  <= tq_of(acc_r);
      default: ;
    endcase
  end

  // held currents, updated only on a computed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r <= '0;
      held_r_r <= '0;
    end else begin
      if (cmd.acc_op == ACC_NEG_CURR) held_r_r <= cur_of(prod_r);
      if (cmd.acc_op == ACC_CURL)     held_l_r <= cur_of(prod_r);
    end
  end

  // result beat: motors offline, remote lost, or held currents
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (moff_r) begin
        out_data_r <= '0;
        out_send_r <= 1'b0;
      end else if (rlost_r) begin
        out_data_r <= '0;
        out_send_r <= 1'b1;
      end else begin
        out_data_r <= {held_r_r, held_l_r};
        out_send_r <= 1'b1;
      end
    end
  end

  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_send_r;

endmodule

### rtl/core/balance_lqr_wheel_current_unit.sv
// Balancing LQR wheel current unit: LQR state feedback to two motor currents.
// A beat runs through the sequencer states from ST_SPD to ST_OUT (straight to ST_OUT in zero-force
// mode), and ST_OUT waits while a previous result beat still waits for out_tready.
// A new beat is taken only in ST_IDLE, after the last one is loaded into the output register;
// the nine products are sequenced through the one shared 30x24 multiplier.
// Reset (rst_n, synchronous, active low) clears gains, held currents and control.
// Depends on blqr_pkg, blqr_ctrl, blqr_dpath.
module balance_lqr_wheel_current_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [blqr_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [blqr_pkg::GAIN_W-1:0]        cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rpm_left, rpm_right, speed_setpoint, pitch_angle, pitch_rate, yaw_rate,
  // heading_error (16 bits each, from bit 0)
  input  logic [blqr_pkg::IN_DATA_W-1:0]     in_tdata,
  // zero_force, remote_lost, motors_offline (from bit 0)
  input  logic [blqr_pkg::IN_USER_W-1:0]     in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // current_left, current_right (16 bits each, from bit 0)
  output logic [blqr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // send_frame
  output logic [blqr_pkg::OUT_USER_W-1:0]    out_tuser
);
  import blqr_pkg::*;

  dp_cmd_t cmd;

  // sequencer
  blqr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_zero_force (in_tuser[UB_ZERO_FORCE]),
    .in_tready     (in_tready),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .cmd           (cmd)
  );

  // arithmetic
  blqr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
